// ===== hdl/heightmap_ray_occlusion_test_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef HEIGHTMAP_RAY_OCCLUSION_TEST_MACROS_SVH
`define HEIGHTMAP_RAY_OCCLUSION_TEST_MACROS_SVH

// Checked only while reset is released.
`define HROT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HROT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hrot_pkg.sv =====
package hrot_pkg;

    localparam int FRAC = 8;
    localparam int CW   = 24;
    localparam int DW   = 19;
    localparam int YW   = 23;
    localparam int NW   = 42;
    localparam int WW   = 44;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HILLS  = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Z = 1'b1;

    localparam logic [1:0] LAST_CORNER = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOOP,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_INTERP,
        ST_RD_LO,
        ST_RD_HI,
        ST_PROD,
        ST_CMP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic       mem_we;
        logic       load_item;
        logic       setup;
        logic       step;
        logic       mul;
        logic       div_start;
        logic       latch_interp;
        logic       rd_en;
        logic       rd_second;
        logic       latch_h1;
        logic       latch_prod;
        logic [1:0] corner;
        logic       axis;
    } t_cmd;

    typedef struct packed {
        logic more;
        logic div_busy;
        logic hit;
    } t_status;

endpackage

// ===== hdl/hrot_div.sv =====
module hrot_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [hrot_pkg::NW-1:0]  i_num,
    input  logic        [hrot_pkg::DW-1:0]  i_den,
    output logic                            o_busy,
    output logic signed [hrot_pkg::NW-1:0]  o_quo
);
    import hrot_pkg::*;

    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_mag;
    logic [DW-1:0]   r_rem;
    logic            r_neg;
    logic [DW:0]     rem_sh;
    logic [DW:0]     rem_sub;
    logic            ge;
    logic            rem_nz;

    assign rem_sh  = {r_rem, r_mag[NW-1]};
    assign ge      = rem_sh >= {1'b0, i_den};
    assign rem_sub = rem_sh - {1'b0, i_den};
    assign rem_nz  = r_rem != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_rem <= '0;
            r_neg <= i_num[NW-1];
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_mag <= {r_mag[NW-2:0], ge};
        end
    end

    // Floor division: a negative quotient with a remainder moves down by one.
    assign o_busy = r_busy;
    assign o_quo  = r_neg ? $signed(~r_mag + NW'(1) - NW'(rem_nz)) : $signed(r_mag);

endmodule

// ===== hdl/hrot_datapath.sv =====
module hrot_datapath #(
    parameter int MAP_SIZE = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [hrot_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [hrot_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [8:0]                             i_cell_row,
    input  logic [8:0]                             i_cell_col,
    input  logic signed [15:0]                     i_cell_height,
    input  logic [8:0]                             i_chunk_left,
    input  logic [8:0]                             i_chunk_right,
    input  logic [8:0]                             i_chunk_top,
    input  logic [8:0]                             i_chunk_bottom,
    input  logic signed [15:0]                     i_chunk_height,
    input  hrot_pkg::t_cmd                         i_cmd,
    output hrot_pkg::t_status                      o_status
);
    import hrot_pkg::*;

    localparam int DIM   = MAP_SIZE + 1;
    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(DIM);
    localparam int HALF  = (MAP_SIZE / 2) * (1 << FRAC);
    localparam logic signed [WW-1:0] MAP_MAX = WW'(MAP_SIZE);

    function automatic logic signed [CW-1:0] f_trunc(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = {v[CW-1:FRAC], {FRAC{1'b0}}};
        if (v[CW-1] && (v[FRAC-1:0] != '0)) begin
            t = t + CW'(1 << FRAC);
        end
        return t;
    endfunction

    function automatic logic [IW-1:0] f_clamp(input logic signed [WW-1:0] v);
        logic [IW-1:0] c;
        if (v < 0) begin
            c = '0;
        end else if (v > MAP_MAX) begin
            c = IW'(MAP_SIZE);
        end else begin
            c = IW'(v);
        end
        return c;
    endfunction

    // Configuration.
    logic signed [16:0] r_view_x;
    logic signed [20:0] r_view_y;
    logic signed [16:0] r_view_z;
    logic signed [15:0] r_hills;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_x <= '0;
            r_view_y <= '0;
            r_view_z <= '0;
            r_hills  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VIEW_X: r_view_x <= i_cfg_data[16:0];
                CFG_VIEW_Y: r_view_y <= i_cfg_data[20:0];
                CFG_VIEW_Z: r_view_z <= i_cfg_data[16:0];
                CFG_HILLS:  r_hills  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Chunk of the current test.
    logic [8:0]         r_left, r_right, r_top, r_bottom;
    logic signed [15:0] r_chunk_h;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_left    <= i_chunk_left;
            r_right   <= i_chunk_right;
            r_top     <= i_chunk_top;
            r_bottom  <= i_chunk_bottom;
            r_chunk_h <= i_chunk_height;
        end
    end

    // Ray setup for one corner and one stepping axis.
    logic signed [CW-1:0] vx, vz, px, pz, dxw, dzw;
    logic signed [DW-1:0] da_c;

    assign vx  = CW'(r_view_x) + CW'(HALF);
    assign vz  = CW'(r_view_z) + CW'(HALF);
    assign px  = $signed(CW'({(i_cmd.corner[0] ? r_right : r_left), {FRAC{1'b0}}}));
    assign pz  = $signed(CW'({(i_cmd.corner[1] ? r_top : r_bottom), {FRAC{1'b0}}}));
    assign dxw = px - vx;
    assign dzw = pz - vz;
    assign da_c = (i_cmd.axis == AXIS_X) ? DW'(dxw) : DW'(dzw);

    logic signed [CW-1:0] r_va, r_pa, r_vb, r_a, r_afix;
    logic signed [DW-1:0] r_db;
    logic [DW-1:0]        r_ad, r_s;
    logic signed [YW-1:0] r_dy;
    logic                 r_pos, r_axis;

    logic signed [CW-1:0] a_new, s_wide;

    assign a_new  = f_trunc(r_pos ? (r_a + CW'(1 << FRAC)) : r_a);
    assign s_wide = a_new - r_va;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_axis <= i_cmd.axis;
            r_va   <= (i_cmd.axis == AXIS_X) ? vx : vz;
            r_a    <= (i_cmd.axis == AXIS_X) ? vx : vz;
            r_pa   <= (i_cmd.axis == AXIS_X) ? px : pz;
            r_vb   <= (i_cmd.axis == AXIS_X) ? vz : vx;
            r_db   <= (i_cmd.axis == AXIS_X) ? DW'(dzw) : DW'(dxw);
            r_ad   <= da_c[DW-1] ? DW'(-da_c) : DW'(da_c);
            r_pos  <= (da_c > 0);
            r_dy   <= YW'(r_chunk_h) - YW'(r_view_y);
        end else if (i_cmd.step) begin
            // Going down, the next crossing lies one unit below this one.
            r_afix <= a_new;
            r_a    <= r_pos ? a_new : (a_new - CW'(1 << FRAC));
            r_s    <= s_wide[CW-1] ? DW'(-s_wide) : DW'(s_wide);
        end
    end

    // Products feeding the two floor divisions.
    logic signed [YW+DW:0]   py_full;
    logic signed [2*DW:0]    pb_full;
    logic signed [NW-1:0]    r_py, r_pb;

    assign py_full = r_dy * $signed({1'b0, r_s});
    assign pb_full = r_db * $signed({1'b0, r_s});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_py <= NW'(py_full);
            r_pb <= NW'(pb_full);
        end
    end

    logic                 busy_y, busy_b;
    logic signed [NW-1:0] qy, qb;

    hrot_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_py),
        .i_den   (r_ad),
        .o_busy  (busy_y),
        .o_quo   (qy)
    );

    hrot_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_pb),
        .i_den   (r_ad),
        .o_busy  (busy_b),
        .o_quo   (qb)
    );

    // Crossing point: ray height, cell pair and fraction.
    logic signed [WW-1:0] ray_c, interp, c1, c2;
    logic [FRAC-1:0]      f_c;

    assign ray_c  = WW'(r_view_y) + WW'(qy);
    assign interp = WW'(r_vb) + WW'(qb);
    assign c1     = interp >>> FRAC;
    assign f_c    = interp[FRAC-1:0];
    assign c2     = c1 + $signed({{(WW-1){1'b0}}, (f_c != '0)});

    logic signed [WW-1:0] r_ray;
    logic [FRAC-1:0]      r_f;
    logic [IW-1:0]        r_ia, r_ib, r_fc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_interp) begin
            r_ray <= ray_c;
            r_f   <= f_c;
            r_ia  <= f_clamp(c1);
            r_ib  <= f_clamp(c2);
            r_fc  <= f_clamp(WW'(r_afix) >>> FRAC);
        end
    end

    // Height map storage.
    logic [IW-1:0]  rd_idx;
    logic [AW-1:0]  raddr, waddr;
    logic           wr_ok;
    logic [15:0]    r_mem [DEPTH];
    logic [15:0]    r_rdata;

    assign rd_idx = i_cmd.rd_second ? r_ib : r_ia;
    assign raddr  = (r_axis == AXIS_X) ? (AW'(rd_idx) * AW'(DIM) + AW'(r_fc))
                                       : (AW'(r_fc) * AW'(DIM) + AW'(rd_idx));
    assign waddr  = AW'(i_cell_row) * AW'(DIM) + AW'(i_cell_col);
    assign wr_ok  = i_cmd.mem_we && (int'(i_cell_row) <= MAP_SIZE)
                    && (int'(i_cell_col) <= MAP_SIZE);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[waddr] <= i_cell_height;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // Linear interpolation and compare.
    logic signed [15:0] r_h1;
    logic signed [16:0] diff;
    logic signed [25:0] prod_c, r_prod;
    logic signed [WW-1:0] hill;

    assign diff   = $signed({r_rdata[15], r_rdata}) - $signed({r_h1[15], r_h1});
    assign prod_c = diff * $signed({1'b0, r_f});

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_h1) begin
            r_h1 <= r_rdata;
        end
        if (i_cmd.latch_prod) begin
            r_prod <= prod_c;
        end
    end

    assign hill = WW'(r_h1) + WW'(r_prod >>> FRAC) + WW'(r_hills);

    assign o_status.more     = r_pos ? (r_a < r_pa) : (r_a > r_pa);
    assign o_status.div_busy = busy_y | busy_b;
    assign o_status.hit      = r_ray < hill;

endmodule

// ===== hdl/hrot_ctrl.sv =====
module hrot_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_operation,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_occluded,
    input  hrot_pkg::t_status    i_status,
    output hrot_pkg::t_cmd       o_cmd
);
    import hrot_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_corner, n_corner;
    logic       r_axis, n_axis;
    logic       r_pend, n_pend;
    logic       r_out_valid, n_out_valid;
    logic       r_out_occ, n_out_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_corner    <= '0;
            r_axis      <= AXIS_X;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_occ   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_corner    <= n_corner;
            r_axis      <= n_axis;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_out_occ   <= n_out_occ;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_corner    = r_corner;
        n_axis      = r_axis;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_ready;
        n_out_occ   = r_out_occ;
        o_cmd        = '0;
        o_cmd.corner = r_corner;
        o_cmd.axis   = r_axis;
        o_ready      = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_operation == OP_WRITE) begin
                        o_cmd.mem_we = 1'b1;
                    end else begin
                        o_cmd.load_item = 1'b1;
                        n_corner = '0;
                        n_axis   = AXIS_X;
                        n_state  = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = ST_LOOP;
            end
            ST_LOOP: begin
                if (i_status.more) begin
                    o_cmd.step = 1'b1;
                    n_state = ST_MUL;
                end else if (r_axis == AXIS_X) begin
                    n_axis  = AXIS_Z;
                    n_state = ST_SETUP;
                end else begin
                    // This corner is visible, so the chunk is too.
                    n_pend  = 1'b0;
                    n_state = ST_FINISH;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_DIV_START;
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = ST_INTERP;
                end
            end
            ST_INTERP: begin
                o_cmd.latch_interp = 1'b1;
                n_state = ST_RD_LO;
            end
            ST_RD_LO: begin
                o_cmd.rd_en = 1'b1;
                n_state = ST_RD_HI;
            end
            ST_RD_HI: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_second = 1'b1;
                o_cmd.latch_h1  = 1'b1;
                n_state = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.latch_prod = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (i_status.hit) begin
                    if (r_corner == LAST_CORNER) begin
                        n_pend  = 1'b1;
                        n_state = ST_FINISH;
                    end else begin
                        n_corner = r_corner + 2'd1;
                        n_axis   = AXIS_X;
                        n_state  = ST_SETUP;
                    end
                end else begin
                    n_state = ST_LOOP;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_occ   = r_pend;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid    = r_out_valid;
    assign o_occluded = r_out_occ;

endmodule

// ===== hdl/heightmap_ray_occlusion_test.sv =====
// Channel   Handshake           Payload
// -------   -----------------   ---------------------------------------------------
// input     i_valid / o_ready   i_operation, i_cell_*, i_chunk_*
// result    o_valid / i_ready   o_occluded (one per chunk test, none per map write)
// config    i_cfg_we            i_cfg_index, i_cfg_data (no wait, no read-back)
//
// A map write is taken without leaving the idle state. A chunk test sets up each ray
// axis and then steps through its grid crossings, each waiting on the bit-serial dividers;
// a test stops early at the first visible corner.
// Reset is synchronous and active low; the height map itself is not cleared.
// A finished result waits in the output register while the next transaction is taken.

module heightmap_ray_occlusion_test #(
    parameter int MAP_SIZE = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hrot_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hrot_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_operation,
    input  logic [8:0]                        i_cell_row,
    input  logic [8:0]                        i_cell_col,
    input  logic signed [15:0]                i_cell_height,
    input  logic [8:0]                        i_chunk_left,
    input  logic [8:0]                        i_chunk_right,
    input  logic [8:0]                        i_chunk_top,
    input  logic [8:0]                        i_chunk_bottom,
    input  logic signed [15:0]                i_chunk_height,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_occluded
);
    import hrot_pkg::*;

    // The controller sequences corners, axes and crossings; the datapath holds
    // the map, the ray registers and the two dividers.
    t_cmd    cmd;
    t_status status;

    hrot_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_occluded  (o_occluded),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    hrot_datapath #(
        .MAP_SIZE (MAP_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_cell_height  (i_cell_height),
        .i_chunk_left   (i_chunk_left),
        .i_chunk_right  (i_chunk_right),
        .i_chunk_top    (i_chunk_top),
        .i_chunk_bottom (i_chunk_bottom),
        .i_chunk_height (i_chunk_height),
        .i_cmd          (cmd),
        .o_status       (status)
    );

endmodule

// ===== hdl/hrot_checker.sv =====
`include "heightmap_ray_occlusion_test_macros.svh"

module hrot_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic i_operation,
    input logic o_valid,
    input logic i_ready,
    input logic o_occluded
);
    import hrot_pkg::*;

    `HROT_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!o_valid && o_ready), "not idle after reset")
    `HROT_ASSERT(a_test_busy, i_clk, i_rst_n, (i_valid && o_ready && i_operation == OP_TEST) |=> !o_ready, "test transaction did not occupy the block")
    `HROT_ASSERT(a_write_ready, i_clk, i_rst_n, (i_valid && o_ready && i_operation == OP_WRITE) |=> o_ready, "map write stalled the input")
    `HROT_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_occluded)), "result changed before it was taken")

endmodule

bind heightmap_ray_occlusion_test hrot_checker u_hrot_checker (.*);

// ===== tb/heightmap_ray_occlusion_test_tb.sv =====
module heightmap_ray_occlusion_test_tb;
    import hrot_pkg::*;

    // Map geometry and fixed-point scale used by the predictor.
    localparam int  MAP_N    = 256;
    localparam int  MAP_DIM  = MAP_N + 1;
    localparam int  UNIT     = 256;
    localparam longint CYCLE_LIMIT = 8000000;

    // Cameras and chunks stay inside two small windows of the map, and every cell of
    // both windows is written first. A ray never leaves the box spanned by its camera
    // cell and its corner, so no test reads a cell that was never written.
    localparam int  WIN_LO   = 124;
    localparam int  WIN_HI   = 132;
    localparam int  EDGE_HI  = 4;
    localparam int  WIN_VIEW = (WIN_HI - WIN_LO) / 2 * UNIT;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    logic                   i_operation;
    logic [8:0]             i_cell_row;
    logic [8:0]             i_cell_col;
    logic signed [15:0]     i_cell_height;
    logic [8:0]             i_chunk_left;
    logic [8:0]             i_chunk_right;
    logic [8:0]             i_chunk_top;
    logic [8:0]             i_chunk_bottom;
    logic signed [15:0]     i_chunk_height;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_occluded;

    heightmap_ray_occlusion_test #(.MAP_SIZE(MAP_N)) DUT (.*);

    // One transaction on the input channel.
    typedef struct {
        logic              op;
        logic [8:0]        row;
        logic [8:0]        col;
        logic signed [15:0] cell_h;
        logic [8:0]        left;
        logic [8:0]        right;
        logic [8:0]        top;
        logic [8:0]        bottom;
        logic signed [15:0] chunk_h;
    } t_item;

    // Predictor state: a private copy of the map and of the view registers.
    shortint   hill_map [MAP_DIM*MAP_DIM];
    longint    cam_x, cam_y, cam_z, hill_ofs;
    logic      occlusion_queue [$];

    int        error_count;
    int        mismatch_count;
    longint    cycle_count;
    bit        idling_on;
    bit        hold_request;

    // Clock with a period of 20 time units.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: ends the run if the block stops making progress.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Floor division, as the fixed-point rules require rounding toward minus infinity.
    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q--;
        end
        return q;
    endfunction

    function automatic longint clamp_cell(longint c);
        if (c < 0) begin
            return 0;
        end
        if (c > MAP_N) begin
            return MAP_N;
        end
        return c;
    endfunction

    // Hill height at a grid crossing: linear blend between the floor and ceil cells
    // along the free axis, plus the global hill offset.
    function automatic longint hill_height(longint interp, longint fixed_pos, bit fixed_is_x);
        longint c1, f, c2, fc, a, b, h1, h2;
        c1 = floor_div(interp, UNIT);
        f  = interp - c1 * UNIT;
        c2 = c1 + ((f != 0) ? 1 : 0);
        fc = clamp_cell(floor_div(fixed_pos, UNIT));
        a  = clamp_cell(c1);
        b  = clamp_cell(c2);
        if (fixed_is_x) begin
            h1 = longint'(hill_map[a*MAP_DIM + fc]);
            h2 = longint'(hill_map[b*MAP_DIM + fc]);
        end else begin
            h1 = longint'(hill_map[fc*MAP_DIM + a]);
            h2 = longint'(hill_map[fc*MAP_DIM + b]);
        end
        return h1 + floor_div((h2 - h1) * f, UNIT) + hill_ofs;
    endfunction

    // Marches one axis of a ray and reports whether any crossing lies under the hills.
    function automatic bit march_axis(longint va, longint pa, longint da, longint vb,
                                      longint db, longint vy, longint dy, bit a_is_x);
        longint pos, span, mag;
        pos = va;
        mag = (da < 0) ? -da : da;
        if (da > 0) begin
            while (pos < pa) begin
                pos  = ((pos + UNIT) / UNIT) * UNIT;
                span = pos - va;
                if (span < 0) begin
                    span = -span;
                end
                if (vy + floor_div(dy * span, mag) <
                    hill_height(vb + floor_div(db * span, mag), pos, a_is_x)) begin
                    return 1'b1;
                end
            end
        end else begin
            while (pos > pa) begin
                pos  = (pos / UNIT) * UNIT;
                span = pos - va;
                if (span < 0) begin
                    span = -span;
                end
                if (vy + floor_div(dy * span, mag) <
                    hill_height(vb + floor_div(db * span, mag), pos, a_is_x)) begin
                    return 1'b1;
                end
                pos -= UNIT;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit corner_hidden(longint px, longint py, longint pz);
        longint vx, vz;
        vx = cam_x + longint'((MAP_N / 2) * UNIT);
        vz = cam_z + longint'((MAP_N / 2) * UNIT);
        if (march_axis(vx, px, px - vx, vz, pz - vz, cam_y, py - cam_y, 1'b1)) begin
            return 1'b1;
        end
        return march_axis(vz, pz, pz - vz, vx, px - vx, cam_y, py - cam_y, 1'b0);
    endfunction

    // Applies one accepted transaction to the predictor.
    task automatic predict_item(t_item it);
        longint l, r, t, b, h;
        bit     occ;
        if (it.op == OP_WRITE) begin
            if (it.row <= MAP_N && it.col <= MAP_N) begin
                hill_map[it.row*MAP_DIM + it.col] = it.cell_h;
            end
        end else begin
            l = longint'(it.left) * UNIT;
            r = longint'(it.right) * UNIT;
            t = longint'(it.top) * UNIT;
            b = longint'(it.bottom) * UNIT;
            h = longint'(it.chunk_h);
            occ = corner_hidden(l, h, b) && corner_hidden(r, h, b) &&
                  corner_hidden(l, h, t) && corner_hidden(r, h, t);
            occlusion_queue = {occlusion_queue, occ};
        end
    endtask

    // Sends one transaction. Valid is only lowered for an idle gap, so it is never
    // lowered and raised in the same time step.
    task automatic send_item(t_item it);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = int'($urandom_range(1, 19));
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= it.op;
        i_cell_row     <= it.row;
        i_cell_col     <= it.col;
        i_cell_height  <= it.cell_h;
        i_chunk_left   <= it.left;
        i_chunk_right  <= it.right;
        i_chunk_top    <= it.top;
        i_chunk_bottom <= it.bottom;
        i_chunk_height <= it.chunk_h;
        // Ready is sampled at the falling edge, where it is settled; the transaction
        // then completes at the following rising edge.
        forever begin
            @(negedge i_clk);
            if (o_ready) begin
                break;
            end
            @(posedge i_clk);
        end
        @(posedge i_clk);
        predict_item(it);
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic wait_drained();
        while (occlusion_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, longint value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_VIEW_X: cam_x    = $signed(value[16:0]);
            CFG_VIEW_Y: cam_y    = $signed(value[20:0]);
            CFG_VIEW_Z: cam_z    = $signed(value[16:0]);
            CFG_HILLS:  hill_ofs = $signed(value[15:0]);
            default: ;
        endcase
    endtask

    task automatic set_view(longint vx, longint vy, longint vz, longint hills);
        wait_drained();
        write_register(CFG_VIEW_X, vx);
        write_register(CFG_VIEW_Y, vy);
        write_register(CFG_VIEW_Z, vz);
        write_register(CFG_HILLS, hills);
    endtask

    function automatic t_item map_write(int row, int col, int h);
        t_item it;
        it = '{default: '0};
        it.op      = OP_WRITE;
        it.row     = 9'(row);
        it.col     = 9'(col);
        it.cell_h  = 16'(h);
        it.left    = 9'($urandom);
        it.right   = 9'($urandom);
        it.top     = 9'($urandom);
        it.bottom  = 9'($urandom);
        it.chunk_h = 16'($urandom);
        return it;
    endfunction

    function automatic t_item chunk_test(int l, int r, int t, int b, int h);
        t_item it;
        it = '{default: '0};
        it.op      = OP_TEST;
        it.row     = 9'($urandom);
        it.col     = 9'($urandom);
        it.cell_h  = 16'($urandom);
        it.left    = 9'(l);
        it.right   = 9'(r);
        it.top     = 9'(t);
        it.bottom  = 9'(b);
        it.chunk_h = 16'(h);
        return it;
    endfunction

    // Any grid line of the central window.
    function automatic int window_edge();
        return int'($urandom_range(WIN_LO, WIN_HI));
    endfunction

    // A camera coordinate that keeps the camera inside the central window.
    function automatic longint window_view();
        return longint'($urandom_range(0, 2 * WIN_VIEW)) - longint'(WIN_VIEW);
    endfunction

    function automatic t_item random_item();
        if ($urandom_range(0, 4) == 0) begin
            // Mostly cells of the window; sometimes a row past the map edge.
            if ($urandom_range(0, 5) == 0) begin
                return map_write(int'($urandom_range(MAP_N + 1, 511)),
                                 int'($urandom_range(0, 511)), int'($urandom));
            end
            return map_write(window_edge(), window_edge(),
                             int'($urandom_range(0, 16383)) - 8192);
        end
        return chunk_test(window_edge(), window_edge(), window_edge(), window_edge(),
                          ($urandom_range(0, 7) == 0) ? int'($urandom) :
                          int'(cam_y) + int'($urandom_range(0, 8191)) - 4096);
    endfunction

    // Receiver: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = 20000;
            end
            if (stall_left == 0 && idling_on && $urandom_range(0, 3) == 0) begin
                stall_left = int'($urandom_range(1, 19));
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Result checker: each transaction on the result channel is compared with the
    // oldest expected occlusion flag.
    initial begin
        logic expected;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (occlusion_queue.size() == 0) begin
                    error_count++;
                    if (mismatch_count < 10) begin
                        $display("unexpected result: occluded=%0b", o_occluded);
                    end
                    mismatch_count++;
                end else begin
                    expected = occlusion_queue.pop_front();
                    if (o_occluded !== expected) begin
                        error_count++;
                        if (mismatch_count < 10) begin
                            $display("occluded mismatch: expected %0b, actual %0b",
                                     expected, o_occluded);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Writes every cell of the central window and of the corner window.
    task automatic test_fill_map();
        for (int r = WIN_LO; r <= WIN_HI; r++) begin
            for (int c = WIN_LO; c <= WIN_HI; c++) begin
                send_item(map_write(r, c, int'($urandom_range(0, 8191)) - 4096));
            end
        end
        for (int r = 0; r <= EDGE_HI; r++) begin
            for (int c = 0; c <= EDGE_HI; c++) begin
                send_item(map_write(r, c, int'($urandom_range(0, 8191)) - 4096));
            end
        end
        drop_valid();
    endtask

    // Extremes of the fields and the special cases, starting from reset values.
    task automatic test_directed();
        // Cells with extreme heights, two at map corners.
        send_item(map_write(0, 0, -32768));
        send_item(map_write(MAP_N, MAP_N, 32767));
        send_item(map_write(128, 129, 32767));
        // Writes past the map edge are ignored.
        send_item(map_write(300, 5, 1234));
        send_item(map_write(5, 511, -1234));
        send_item(map_write(511, 511, 77));
        // Chunk edge on the camera line: a zero direction component.
        send_item(chunk_test(128, 130, 130, 128, 0));
        send_item(chunk_test(128, 128, 128, 128, 100));
        // Extreme chunk heights.
        send_item(chunk_test(126, 131, 125, 132, 32767));
        send_item(chunk_test(126, 131, 125, 132, -32768));
        drop_valid();
        // A camera off the grid lines.
        set_view(32'h80, -2000, -32'h40, 500);
        send_item(chunk_test(131, 124, 132, 125, -3000));
        send_item(chunk_test(125, 132, 124, 131, 0));
        drop_valid();
        // Camera on the low map corner with extreme height and offset.
        set_view(-32768, 1048575, -32768, -32768);
        send_item(chunk_test(EDGE_HI, 0, 0, 3, -32768));
        send_item(chunk_test(0, 3, EDGE_HI, 1, 32767));
        drop_valid();
        // Camera just off the map, so map reads clamp to the edge.
        set_view(-33000, -1048576, -32900, 32767);
        send_item(chunk_test(3, 1, 2, EDGE_HI, 0));
        send_item(chunk_test(0, 0, 0, 0, 5));
        drop_valid();
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) begin
            send_item(random_item());
        end
        drop_valid();
    endtask

    // Several camera settings, each followed by random traffic.
    task automatic test_view_settings();
        set_view(0, 0, 0, 0);
        run_random(30);
        set_view(-WIN_VIEW, -1048576, WIN_VIEW, -32768);
        run_random(20);
        set_view(WIN_VIEW, 1048575, -WIN_VIEW, 32767);
        run_random(20);
        for (int k = 0; k < 4; k++) begin
            set_view(window_view(),
                     longint'($urandom_range(0, 8191)) - 4096,
                     window_view(),
                     longint'($urandom_range(0, 4095)) - 2048);
            run_random(20);
        end
    endtask

    // The receiver holds off while the sender keeps offering chunk tests, so the
    // output register fills and the input stalls.
    task automatic test_backpressure();
        set_view(0, 0, 0, 0);
        hold_request = 1'b1;
        for (int n = 0; n < 8; n++) begin
            send_item(chunk_test(window_edge(), window_edge(), window_edge(),
                                 window_edge(), int'($urandom_range(0, 8191)) - 4096));
        end
        drop_valid();
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_final_burst();
        set_view(window_view(), 0, window_view(), 0);
        idling_on = 1'b0;
        run_random(10);
    endtask

    initial begin
        error_count    = 0;
        mismatch_count = 0;
        idling_on      = 1'b0;
        hold_request   = 1'b0;
        cam_x = 0;
        cam_y = 0;
        cam_z = 0;
        hill_ofs = 0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_operation    <= OP_WRITE;
        i_cell_row     <= '0;
        i_cell_col     <= '0;
        i_cell_height  <= '0;
        i_chunk_left   <= '0;
        i_chunk_right  <= '0;
        i_chunk_top    <= '0;
        i_chunk_bottom <= '0;
        i_chunk_height <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_map();
        idling_on = 1'b1;
        test_directed();
        test_view_settings();
        test_backpressure();
        test_final_burst();

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && occlusion_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
